// ----- hdl/saa_pkg.sv -----
// Shared types, constants and tables for the solar azimuth pipeline.
// No dependencies; used by saa_sincos, saa_vector and solar_azimuth_angle_core.
package saa_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int NSTEP = (CORDIC_STEPS < 1) ? 1 : ((CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS);

    // register stages of one sin/cos unit: fold stage plus one per step
    localparam int LAT_SC = NSTEP + 1;
    // total register stages from input to output registers
    localparam int LAT    = 12 + 2 * LAT_SC + NSTEP;

    localparam int SC_W  = 34;
    localparam int VEC_W = 36;
    localparam int Z_W   = 34;

    typedef logic signed [31:0]      t_q30;
    typedef logic        [31:0]      t_phase;
    typedef logic signed [SC_W-1:0]  t_sc;
    typedef logic signed [VEC_W-1:0] t_vec;
    typedef logic signed [Z_W-1:0]   t_z;

    typedef struct packed {
        t_phase ha;
        t_phase el;
        t_phase lat;
    } t_phases;

    // atan(2^-i) in turn units, 2^32 per turn
    localparam logic [31:0] ATAN_TURN [32] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10680862,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5,
        32'd3,         32'd1,         32'd1,         32'd0
    };

    localparam t_sc GAIN_Q30     = t_sc'(64'sd652032874);
    localparam t_sc QUARTER_TURN = t_sc'(64'sd1073741824);
    localparam t_sc HALF_TURN    = t_sc'(64'sd2147483648);
    localparam t_z  HALF_TURN_Z  = t_z'(64'sd2147483648);

    // day phase: |d| * 2^32 / 365, scaled by 2^20 for rounding
    localparam int          DAY_FRAC   = 20;
    localparam logic [43:0] DAY_RECIP  = 44'(((64'd1 << 52) + 64'd182) / 64'd365);
    localparam logic [53:0] DAY_ROUND  = 54'd1 << (DAY_FRAC - 1);

    // centidegree phase: |a| * 2^27 / 1125, scaled by 2^28 for rounding
    localparam int          CENT_FRAC  = 28;
    localparam logic [44:0] CENT_RECIP = 45'(((64'd1 << 55) + 64'd562) / 64'd1125);
    localparam logic [60:0] CENT_ROUND = 61'd1 << (CENT_FRAC - 1);

    // declination phase: round(|s| * 469 / 1800)
    localparam logic [30:0] DEC_RECIP  = 31'((64'd469 << 32) / 64'd1800);
    localparam logic [9:0]  DEC_MUL    = 10'd469;
    localparam logic [9:0]  DEC_BIAS   = 10'd900;
    localparam logic [12:0] DEC_DIV    = 13'd1800;
    localparam logic [12:0] DEC_DIV2   = 13'd3600;

    // phase to centidegrees: p * 1125 / 2^27
    localparam logic signed [42:0] FINE_MUL   = 43'sd1125;
    localparam int                 FINE_SHIFT = 27;
    localparam logic [42:0]        FINE_ROUND = 43'd1 << (FINE_SHIFT - 1);

    // centidegrees to degrees: (f + 50) / 100 by reciprocal
    localparam logic [15:0] WHOLE_RECIP = 16'd41944;
    localparam int          WHOLE_SHIFT = 22;
    localparam logic [14:0] WHOLE_BIAS  = 15'd50;

    localparam logic signed [14:0] LAT_RESET = 15'sd4885;
    localparam logic signed [14:0] LAT_MAX   = 15'sd8999;
    localparam logic signed [14:0] LAT_MIN   = -15'sd8999;
    localparam logic signed [14:0] EL_LIMIT  = 15'sd9000;
    localparam logic signed [10:0] DAY_ZERO  = 11'sd81;

endpackage

// ----- hdl/solar_azimuth_angle_core.sv -----
// Solar azimuth core: declination from day of year, then atan2 over a CORDIC pipeline.
// Depends on saa_pkg, saa_sincos and saa_vector.
//
//   channel | handshake                  | payload
//   --------+----------------------------+--------------------------------------------
//   in      | i_in_valid / o_in_ready    | i_hour_angle, i_elevation, i_day_of_year
//   out     | o_out_valid / i_out_ready  | o_azimuth_fine, o_azimuth_whole,
//           |                            | o_undefined_flag
//   cfg     | i_cfg_valid / o_cfg_ready  | i_site_latitude
//
// One transaction per cycle enters while the output is not stalled; the pipeline depth,
// saa_pkg::LAT, is set by two chained sine/cosine CORDICs and one atan2 CORDIC.
// The whole pipeline advances together whenever the output register is empty or taken;
// while the output stalls, every stage holds, so nothing is lost or repeated.
// Reset (synchronous, active low) clears the valid bits and loads the latitude default.
// Latitude is sampled when an input transaction is accepted.
module solar_azimuth_angle_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [15:0] i_hour_angle,
    input  logic signed [14:0] i_elevation,
    input  logic        [8:0]  i_day_of_year,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [15:0] o_azimuth_fine,
    output logic signed [8:0]  o_azimuth_whole,
    output logic               o_undefined_flag,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic signed [14:0] i_site_latitude
);

    localparam int LS = saa_pkg::LAT_SC;
    localparam int LT = saa_pkg::LAT;

    logic adv;

    // config register
    logic signed [14:0] r_lat;

    // valid and undefined flag travel along every stage
    logic r_vld [0:LT-1];
    logic r_flg [0:LT-1];

    // S1: captured inputs
    logic signed [15:0] r1_ha;
    logic signed [14:0] r1_el;
    logic        [8:0]  r1_day;
    logic signed [14:0] r1_lat;
    logic signed [14:0] n_lat_sat;
    logic               n_undef;

    // S2: magnitude times reciprocal
    logic signed [10:0] n2_d;
    logic        [9:0]  n2_dmag;
    logic        [15:0] n2_hmag;
    logic        [14:0] n2_emag;
    logic        [14:0] n2_lmag;
    logic        [53:0] r2_pd;
    logic        [60:0] r2_ph;
    logic        [60:0] r2_pe;
    logic        [60:0] r2_pl;
    logic               r2_dneg, r2_hneg, r2_eneg, r2_lneg;

    // S3: phases
    logic        [32:0] n3_qd, n3_qh, n3_qe, n3_ql;
    saa_pkg::t_phase    r3_pday;
    saa_pkg::t_phases   r3_ph;

    // declination
    saa_pkg::t_q30      w_sa;
    logic        [30:0] n_samag;
    logic        [61:0] n_q0prod;
    logic        [39:0] n_pprod;
    logic        [29:0] r_d1_q0;
    logic        [12:0] r_d1_p;
    logic               r_d1_neg;
    logic        [12:0] n_q1800;
    logic        [12:0] n_rem;
    logic        [29:0] n_t;
    saa_pkg::t_phase    r_dph;
    saa_pkg::t_phases   r_pdl [0:LS+1];

    // second sin/cos bank
    saa_pkg::t_q30      w_sd, w_cd, w_sh_ha, w_s_el, w_s_lat, w_c_lat;

    // products
    logic signed [63:0] n_cdsh;
    logic signed [63:0] n_shsl;
    logic signed [32:0] n_shsl_s;
    logic signed [32:0] r_m1_y;
    logic signed [33:0] r_m1_x;
    saa_pkg::t_q30      r_m1_cl;
    logic signed [64:0] n_ycl;
    logic signed [33:0] r_m2_y;
    logic signed [33:0] r_m2_x;

    // atan2 front end
    logic               n_a_neg;
    saa_pkg::t_sc       n_a_x, n_a_y;
    logic        [33:0] n_a_mag;
    logic        [5:0]  n_a_pos;
    logic        [4:0]  n_a_sh;
    saa_pkg::t_sc       r_a1_x, r_a1_y;
    logic        [4:0]  r_a1_sh;
    logic               r_a1_half;
    logic               r_a1_zero;
    saa_pkg::t_phase    w_phase;

    // output conversion
    logic signed [42:0] r_c1_n;
    logic        [42:0] n_c2_mag;
    logic        [14:0] r_c2_f;
    logic               r_c2_neg;
    logic        [30:0] n_c3_prod;
    logic        [7:0]  n_c3_w;
    logic signed [15:0] r_fine;
    logic signed [8:0]  r_whole;

    // the pipeline moves unless a finished result is waiting
    assign adv         = !r_vld[LT-1] || i_out_ready;
    assign o_in_ready  = adv;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lat <= saa_pkg::LAT_RESET;
        end else if (i_cfg_valid) begin
            r_lat <= i_site_latitude;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LT; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (adv) begin
            r_vld[0] <= i_in_valid;
            for (int k = 1; k < LT; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_flg[0] <= n_undef;
            for (int k = 1; k < LT; k++) begin
                r_flg[k] <= r_flg[k-1];
            end
        end
    end

    // ---------------- S1: capture, latitude clamp, pole check
    always_comb begin
        if (r_lat > saa_pkg::LAT_MAX) begin
            n_lat_sat = saa_pkg::LAT_MAX;
        end else if (r_lat < saa_pkg::LAT_MIN) begin
            n_lat_sat = saa_pkg::LAT_MIN;
        end else begin
            n_lat_sat = r_lat;
        end
        n_undef = (i_elevation >= saa_pkg::EL_LIMIT) || (i_elevation <= -saa_pkg::EL_LIMIT);
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_ha  <= i_hour_angle;
            r1_el  <= i_elevation;
            r1_day <= i_day_of_year;
            r1_lat <= n_lat_sat;
        end
    end

    // ---------------- S2: magnitudes times fixed reciprocals
    always_comb begin
        n2_d    = $signed({2'b00, r1_day}) - saa_pkg::DAY_ZERO;
        n2_dmag = n2_d[10] ? 10'(-n2_d) : n2_d[9:0];
        n2_hmag = r1_ha[15] ? 16'(-r1_ha) : 16'(r1_ha);
        n2_emag = r1_el[14] ? 15'(-r1_el) : 15'(r1_el);
        n2_lmag = r1_lat[14] ? 15'(-r1_lat) : 15'(r1_lat);
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r2_pd   <= 54'(n2_dmag) * 54'(saa_pkg::DAY_RECIP);
            r2_ph   <= 61'(n2_hmag) * 61'(saa_pkg::CENT_RECIP);
            r2_pe   <= 61'(n2_emag) * 61'(saa_pkg::CENT_RECIP);
            r2_pl   <= 61'(n2_lmag) * 61'(saa_pkg::CENT_RECIP);
            r2_dneg <= n2_d[10];
            r2_hneg <= r1_ha[15];
            r2_eneg <= r1_el[14];
            r2_lneg <= r1_lat[14];
        end
    end

    // ---------------- S3: round half away from zero, wrap to a 32-bit phase
    always_comb begin
        n3_qd = 33'((r2_pd + saa_pkg::DAY_ROUND) >> saa_pkg::DAY_FRAC);
        n3_qh = 33'((r2_ph + saa_pkg::CENT_ROUND) >> saa_pkg::CENT_FRAC);
        n3_qe = 33'((r2_pe + saa_pkg::CENT_ROUND) >> saa_pkg::CENT_FRAC);
        n3_ql = 33'((r2_pl + saa_pkg::CENT_ROUND) >> saa_pkg::CENT_FRAC);
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r3_pday   <= r2_dneg ? 32'(-n3_qd) : n3_qd[31:0];
            r3_ph.ha  <= r2_hneg ? 32'(-n3_qh) : n3_qh[31:0];
            r3_ph.el  <= r2_eneg ? 32'(-n3_qe) : n3_qe[31:0];
            r3_ph.lat <= r2_lneg ? 32'(-n3_ql) : n3_ql[31:0];
        end
    end

    // ---------------- seasonal sine
    saa_sincos u_sc_day (
        .i_clk   (i_clk),
        .i_en    (adv),
        .i_phase (r3_pday),
        .o_sin   (w_sa),
        .o_cos   ()
    );

    // ---------------- declination phase = round(|s| * 469 / 1800), sign restored
    // D1 takes a reciprocal estimate that is at most two short; D2 fixes it
    // from the low bits of the remainder.
    always_comb begin
        n_samag  = w_sa[31] ? 31'(-w_sa) : w_sa[30:0];
        n_q0prod = 62'(n_samag) * 62'(saa_pkg::DEC_RECIP);
        n_pprod  = 40'(n_samag) * 40'(saa_pkg::DEC_MUL) + 40'(saa_pkg::DEC_BIAS);
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_d1_q0  <= n_q0prod[61:32];
            r_d1_p   <= n_pprod[12:0];
            r_d1_neg <= w_sa[31];
        end
    end

    always_comb begin
        n_q1800 = 13'(26'(r_d1_q0[12:0]) * 26'(saa_pkg::DEC_DIV));
        n_rem   = r_d1_p - n_q1800;
        n_t     = r_d1_q0 + 30'(n_rem >= saa_pkg::DEC_DIV) + 30'(n_rem >= saa_pkg::DEC_DIV2);
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_dph <= r_d1_neg ? 32'(-{2'b00, n_t}) : {2'b00, n_t};
        end
    end

    // other phases wait for the declination
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_pdl[0] <= r3_ph;
            for (int k = 1; k < LS + 2; k++) begin
                r_pdl[k] <= r_pdl[k-1];
            end
        end
    end

    saa_sincos u_sc_dec (
        .i_clk   (i_clk),
        .i_en    (adv),
        .i_phase (r_dph),
        .o_sin   (w_sd),
        .o_cos   (w_cd)
    );

    saa_sincos u_sc_ha (
        .i_clk   (i_clk),
        .i_en    (adv),
        .i_phase (r_pdl[LS+1].ha),
        .o_sin   (w_sh_ha),
        .o_cos   ()
    );

    saa_sincos u_sc_el (
        .i_clk   (i_clk),
        .i_en    (adv),
        .i_phase (r_pdl[LS+1].el),
        .o_sin   (w_s_el),
        .o_cos   ()
    );

    saa_sincos u_sc_lat (
        .i_clk   (i_clk),
        .i_en    (adv),
        .i_phase (r_pdl[LS+1].lat),
        .o_sin   (w_s_lat),
        .o_cos   (w_c_lat)
    );

    // ---------------- M1: Y1 = cosD*sinH >> 30, X = sin h*sin lat >> 30 - sinD
    always_comb begin
        n_cdsh   = 64'(w_cd) * 64'(w_sh_ha);
        n_shsl   = 64'(w_s_el) * 64'(w_s_lat);
        n_shsl_s = $signed(n_shsl[62:30]);
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_m1_y  <= $signed(n_cdsh[62:30]);
            r_m1_x  <= 34'(n_shsl_s) - 34'(w_sd);
            r_m1_cl <= w_c_lat;
        end
    end

    // ---------------- M2: Y = Y1*cos lat >> 30
    assign n_ycl = 65'(r_m1_y) * 65'(r_m1_cl);

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_m2_y <= $signed(n_ycl[63:30]);
            r_m2_x <= r_m1_x;
        end
    end

    // ---------------- A1: move to the right half plane, find the normalize shift
    always_comb begin
        n_a_neg = r_m2_x[33];
        n_a_x   = n_a_neg ? -r_m2_x : r_m2_x;
        n_a_y   = n_a_neg ? -r_m2_y : r_m2_y;
        n_a_mag = 34'(n_a_x) | 34'(n_a_y[33] ? -n_a_y : n_a_y);
        n_a_pos = '0;
        for (int k = 0; k < 34; k++) begin
            if (n_a_mag[k]) begin
                n_a_pos = 6'(k);
            end
        end
        // doubling stops once either magnitude reaches 2^30
        n_a_sh = (n_a_pos >= 6'd30) ? 5'd0 : 5'(6'd30 - n_a_pos);
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_a1_x    <= n_a_x;
            r_a1_y    <= n_a_y;
            r_a1_sh   <= n_a_sh;
            r_a1_half <= n_a_neg;
            r_a1_zero <= (r_m2_x == '0) && (r_m2_y == '0);
        end
    end

    saa_vector u_vec (
        .i_clk   (i_clk),
        .i_en    (adv),
        .i_x     (r_a1_x),
        .i_y     (r_a1_y),
        .i_shift (r_a1_sh),
        .i_half  (r_a1_half),
        .i_zero  (r_a1_zero),
        .o_phase (w_phase)
    );

    // ---------------- C1..C3: phase to centidegrees, then whole degrees
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_c1_n <= 43'($signed(w_phase)) * saa_pkg::FINE_MUL;
        end
    end

    assign n_c2_mag = r_c1_n[42] ? 43'(-r_c1_n) : 43'(r_c1_n);

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_c2_f   <= 15'((n_c2_mag + saa_pkg::FINE_ROUND) >> saa_pkg::FINE_SHIFT);
            r_c2_neg <= r_c1_n[42];
        end
    end

    always_comb begin
        n_c3_prod = 31'(r_c2_f + saa_pkg::WHOLE_BIAS) * 31'(saa_pkg::WHOLE_RECIP);
        n_c3_w    = 8'(n_c3_prod >> saa_pkg::WHOLE_SHIFT);
    end

    // pole case forces both azimuth fields to zero
    always_ff @(posedge i_clk) begin
        if (adv) begin
            if (r_flg[LT-2]) begin
                r_fine  <= '0;
                r_whole <= '0;
            end else begin
                r_fine  <= r_c2_neg ? -$signed({1'b0, r_c2_f}) : $signed({1'b0, r_c2_f});
                r_whole <= r_c2_neg ? -$signed({1'b0, n_c3_w}) : $signed({1'b0, n_c3_w});
            end
        end
    end

    assign o_out_valid      = r_vld[LT-1];
    assign o_undefined_flag = r_flg[LT-1];
    assign o_azimuth_fine   = r_fine;
    assign o_azimuth_whole  = r_whole;

endmodule

// ----- hdl/saa_sincos.sv -----
// Pipelined rotation-mode CORDIC: phase in, sine and cosine in Q30 out.
// Depends on saa_pkg; saa_pkg::LAT_SC register stages deep, advancing on i_en.
module saa_sincos (
    input  logic            i_clk,
    input  logic            i_en,
    input  saa_pkg::t_phase i_phase,
    output saa_pkg::t_q30   o_sin,
    output saa_pkg::t_q30   o_cos
);

    saa_pkg::t_sc r_x    [0:saa_pkg::NSTEP];
    saa_pkg::t_sc r_y    [0:saa_pkg::NSTEP];
    saa_pkg::t_sc r_z    [0:saa_pkg::NSTEP-1];
    logic         r_flip [0:saa_pkg::NSTEP];

    saa_pkg::t_sc n_z;
    logic         n_flip;

    // fold into [-90, 90] deg, results negated later
    always_comb begin
        n_z    = saa_pkg::t_sc'($signed(i_phase));
        n_flip = 1'b0;
        if (n_z > saa_pkg::QUARTER_TURN) begin
            n_z    = n_z - saa_pkg::HALF_TURN;
            n_flip = 1'b1;
        end else if (n_z < -saa_pkg::QUARTER_TURN) begin
            n_z    = n_z + saa_pkg::HALF_TURN;
            n_flip = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]    <= saa_pkg::GAIN_Q30;
            r_y[0]    <= '0;
            r_z[0]    <= n_z;
            r_flip[0] <= n_flip;
        end
    end

    for (genvar gi = 0; gi < saa_pkg::NSTEP; gi++) begin : g_step
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_flip[gi+1] <= r_flip[gi];
                if (!r_z[gi][saa_pkg::SC_W-1]) begin
                    r_x[gi+1] <= r_x[gi] - (r_y[gi] >>> gi);
                    r_y[gi+1] <= r_y[gi] + (r_x[gi] >>> gi);
                end else begin
                    r_x[gi+1] <= r_x[gi] + (r_y[gi] >>> gi);
                    r_y[gi+1] <= r_y[gi] - (r_x[gi] >>> gi);
                end
            end
        end
        if (gi < saa_pkg::NSTEP - 1) begin : g_z
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    if (!r_z[gi][saa_pkg::SC_W-1]) begin
                        r_z[gi+1] <= r_z[gi] - saa_pkg::t_sc'(saa_pkg::ATAN_TURN[gi]);
                    end else begin
                        r_z[gi+1] <= r_z[gi] + saa_pkg::t_sc'(saa_pkg::ATAN_TURN[gi]);
                    end
                end
            end
        end
    end

    assign o_sin = saa_pkg::t_q30'(r_flip[saa_pkg::NSTEP] ? -r_y[saa_pkg::NSTEP]
                                                           : r_y[saa_pkg::NSTEP]);
    assign o_cos = saa_pkg::t_q30'(r_flip[saa_pkg::NSTEP] ? -r_x[saa_pkg::NSTEP]
                                                           : r_x[saa_pkg::NSTEP]);

endmodule

// ----- hdl/saa_vector.sv -----
// Pipelined vectoring-mode CORDIC for atan2: normalize shift, then one step per stage.
// Depends on saa_pkg; saa_pkg::NSTEP + 1 register stages deep, advancing on i_en.
module saa_vector (
    input  logic            i_clk,
    input  logic            i_en,
    input  saa_pkg::t_sc    i_x,
    input  saa_pkg::t_sc    i_y,
    input  logic [4:0]      i_shift,
    input  logic            i_half,
    input  logic            i_zero,
    output saa_pkg::t_phase o_phase
);

    saa_pkg::t_vec r_x    [0:saa_pkg::NSTEP-1];
    saa_pkg::t_vec r_y    [0:saa_pkg::NSTEP-1];
    saa_pkg::t_z   r_z    [0:saa_pkg::NSTEP];
    logic          r_zero [0:saa_pkg::NSTEP];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]    <= saa_pkg::t_vec'(i_x) <<< i_shift;
            r_y[0]    <= saa_pkg::t_vec'(i_y) <<< i_shift;
            r_z[0]    <= i_half ? saa_pkg::HALF_TURN_Z : '0;
            r_zero[0] <= i_zero;
        end
    end

    for (genvar gi = 0; gi < saa_pkg::NSTEP; gi++) begin : g_step
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_zero[gi+1] <= r_zero[gi];
                if (r_y[gi] > 0) begin
                    r_z[gi+1] <= r_z[gi] + saa_pkg::t_z'(saa_pkg::ATAN_TURN[gi]);
                end else begin
                    r_z[gi+1] <= r_z[gi] - saa_pkg::t_z'(saa_pkg::ATAN_TURN[gi]);
                end
            end
        end
        if (gi < saa_pkg::NSTEP - 1) begin : g_xy
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    if (r_y[gi] > 0) begin
                        r_x[gi+1] <= r_x[gi] + (r_y[gi] >>> gi);
                        r_y[gi+1] <= r_y[gi] - (r_x[gi] >>> gi);
                    end else begin
                        r_x[gi+1] <= r_x[gi] - (r_y[gi] >>> gi);
                        r_y[gi+1] <= r_y[gi] + (r_x[gi] >>> gi);
                    end
                end
            end
        end
    end

    // both components zero: azimuth defined as zero
    assign o_phase = r_zero[saa_pkg::NSTEP] ? '0 : r_z[saa_pkg::NSTEP][31:0];

endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench for solar_azimuth_angle_core.
// Depends on saa_pkg (step count, latency, atan table, latitude reset) and the core RTL.
`timescale 1ns / 100ps

module testbench;

    typedef struct {
        logic signed [15:0] fine;
        logic signed [8:0]  whole;
        logic               flag;
    } t_azimuth;

    typedef struct {
        logic signed [15:0] ha;
        logic signed [14:0] el;
        logic        [8:0]  day;
        logic               fixed;   // expected result typed in below
        t_azimuth           result;
    } t_stim_row;

    localparam longint TURN_L    = 64'sd4294967296;
    localparam longint HALF_L    = 64'sd2147483648;
    localparam longint QUARTER_L = 64'sd1073741824;
    localparam longint K_Q30     = 64'sd652032874;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic signed [15:0] i_hour_angle;
    logic signed [14:0] i_elevation;
    logic        [8:0]  i_day_of_year;
    logic               o_out_valid;
    logic               i_out_ready;
    logic signed [15:0] o_azimuth_fine;
    logic signed [8:0]  o_azimuth_whole;
    logic               o_undefined_flag;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic signed [14:0] i_site_latitude;

    t_azimuth           pending_azimuths[$];
    logic signed [14:0] latitude_shadow;
    int                 errors;
    bit                 hold_request;

    solar_azimuth_angle_core DUT (.*);

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // ---------------- predictor ----------------
    function automatic longint round_div(longint n, longint d);
        if (n >= 0) return (n + d / 2) / d;
        return -((-n + d / 2) / d);
    endfunction

    function automatic longint phase_to_signed(logic [31:0] p);
        longint z;
        z = $signed(p);
        return z;
    endfunction

    // rotation-mode CORDIC, phase folded into +-90 deg first
    function automatic void cordic_sin_cos(input logic [31:0] p,
                                           output longint s, output longint c);
        longint z, x, y, t;
        bit     flip;
        z = phase_to_signed(p);
        x = K_Q30;
        y = 0;
        flip = 1'b0;
        if (z > QUARTER_L) begin
            z -= HALF_L;
            flip = 1'b1;
        end else if (z < -QUARTER_L) begin
            z += HALF_L;
            flip = 1'b1;
        end
        for (int i = 0; i < saa_pkg::NSTEP; i++) begin
            if (z >= 0) begin
                t = x - (y >>> i);
                y = y + (x >>> i);
                z -= longint'(saa_pkg::ATAN_TURN[i]);
            end else begin
                t = x + (y >>> i);
                y = y - (x >>> i);
                z += longint'(saa_pkg::ATAN_TURN[i]);
            end
            x = t;
        end
        s = flip ? -y : y;
        c = flip ? -x : x;
    endfunction

    // vectoring-mode CORDIC, returns phase as a 32-bit turn fraction
    function automatic logic [31:0] cordic_atan2(longint y, longint x);
        longint z, t;
        z = 0;
        if (x == 0 && y == 0) return '0;
        if (x < 0) begin
            x = -x;
            y = -y;
            z = HALF_L;
        end
        while ((x < 0 ? -x : x) < QUARTER_L && (y < 0 ? -y : y) < QUARTER_L) begin
            x *= 2;
            y *= 2;
        end
        for (int i = 0; i < saa_pkg::NSTEP; i++) begin
            if (y > 0) begin
                t = x + (y >>> i);
                y = y - (x >>> i);
                z += longint'(saa_pkg::ATAN_TURN[i]);
            end else begin
                t = x - (y >>> i);
                y = y + (x >>> i);
                z -= longint'(saa_pkg::ATAN_TURN[i]);
            end
            x = t;
        end
        return z[31:0];
    endfunction

    function automatic t_azimuth predict_azimuth(logic signed [15:0] ha,
                                                 logic signed [14:0] el,
                                                 logic [8:0] day,
                                                 logic signed [14:0] lat_reg);
        t_azimuth r;
        longint   h, e, d, lat, sa, ca, sd, cd, sh, ch, se, ce, sl, cl, yv, xv, fine;
        longint   dec_p, ha_p, el_p, lat_p, whole;
        h = ha;
        e = el;
        d = day;
        lat = lat_reg;
        if (lat > 8999) lat = 8999;
        if (lat < -8999) lat = -8999;
        r = '{fine: '0, whole: '0, flag: 1'b0};
        if (e >= 9000 || e <= -9000) begin
            r.flag = 1'b1;
            return r;
        end
        dec_p = round_div((d - 81) * TURN_L, 365);
        cordic_sin_cos(dec_p[31:0], sa, ca);
        dec_p = round_div(2345 * 4 * sa, 36000);
        cordic_sin_cos(dec_p[31:0], sd, cd);
        ha_p  = round_div(h * TURN_L, 36000);
        el_p  = round_div(e * TURN_L, 36000);
        lat_p = round_div(lat * TURN_L, 36000);
        cordic_sin_cos(ha_p[31:0], sh, ch);
        cordic_sin_cos(el_p[31:0], se, ce);
        cordic_sin_cos(lat_p[31:0], sl, cl);
        yv = (((cd * sh) >>> 30) * cl) >>> 30;
        xv = ((se * sl) >>> 30) - sd;
        fine = round_div(phase_to_signed(cordic_atan2(yv, xv)) * 36000, TURN_L);
        whole = round_div(fine, 100);
        r.fine  = fine[15:0];
        r.whole = whole[8:0];
        return r;
    endfunction

    // ---------------- drivers ----------------
    // Offer one transaction; valid stays up until the core takes it.
    task automatic send_sample(logic signed [15:0] ha, logic signed [14:0] el,
                               logic [8:0] day, logic fixed, t_azimuth fixed_result);
        i_in_valid    <= 1'b1;
        i_hour_angle  <= ha;
        i_elevation   <= el;
        i_day_of_year <= day;
        do @(posedge i_clk); while (!o_in_ready);
        pending_azimuths.push_back(fixed ? fixed_result
                                   : predict_azimuth(ha, el, day, latitude_shadow));
    endtask

    task automatic idle_cycles(int n);
        i_in_valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // Latitude writes only with the pipeline drained.
    task automatic write_latitude(logic signed [14:0] lat);
        idle_cycles(1);
        wait (pending_azimuths.size() == 0);
        repeat (saa_pkg::LAT + 4) @(posedge i_clk);
        i_cfg_valid     <= 1'b1;
        i_site_latitude <= lat;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid     <= 1'b0;
        latitude_shadow = lat;
    endtask

    task automatic random_burst_traffic(int count);
        int left;
        int burst;
        logic signed [15:0] ha;
        logic signed [14:0] el;
        logic [8:0]         day;
        left = count;
        while (left > 0) begin
            burst = $urandom_range(1, 30);
            if (burst > left) burst = left;
            for (int k = 0; k < burst; k++) begin
                // mostly in-range values, sometimes the full field width
                ha  = ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                                  : 16'($signed($urandom_range(0, 36000)) - 18000);
                el  = ($urandom_range(0, 7) == 0) ? 15'($urandom)
                                                  : 15'($signed($urandom_range(0, 17998)) - 8999);
                day = ($urandom_range(0, 7) == 0) ? 9'($urandom) : 9'($urandom_range(1, 366));
                send_sample(ha, el, day, 1'b0, '{fine: '0, whole: '0, flag: 1'b0});
            end
            left -= burst;
            if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 8));
        end
    endtask

    // ---------------- receiver ----------------
    // Stall pattern is drawn at random from four modes; a hold request freezes it for a long stretch.
    initial begin
        int hold_left;
        int cyc;
        int mode;
        hold_left = 0;
        cyc = 0;
        mode = 0;
        i_out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            cyc++;
            if (cyc % 64 == 0) mode = $urandom_range(0, 3);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left = 4 * saa_pkg::LAT;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                case (mode)
                    0: i_out_ready <= 1'b1;
                    1: i_out_ready <= ($urandom_range(0, 9) < 7);
                    2: i_out_ready <= (cyc % 3 == 0);
                    default: i_out_ready <= $urandom_range(0, 1);
                endcase
            end
        end
    end

    // ---------------- result checker ----------------
    always @(posedge i_clk) begin
        t_azimuth want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_azimuths.size() == 0) begin
                $error("unexpected transaction: fine %0d whole %0d flag %0b",
                       o_azimuth_fine, o_azimuth_whole, o_undefined_flag);
                errors++;
            end else begin
                want = pending_azimuths.pop_front();
                if (o_azimuth_fine !== want.fine) begin
                    $error("azimuth_fine: expected %0d, got %0d", want.fine, o_azimuth_fine);
                    errors++;
                end
                if (o_azimuth_whole !== want.whole) begin
                    $error("azimuth_whole: expected %0d, got %0d", want.whole, o_azimuth_whole);
                    errors++;
                end
                if (o_undefined_flag !== want.flag) begin
                    $error("undefined_flag: expected %0b, got %0b", want.flag, o_undefined_flag);
                    errors++;
                end
            end
        end
    end

    // ---------------- main sequence ----------------
    initial begin
        t_stim_row directed_rows[$];
        t_azimuth  flagged;
        flagged = '{fine: '0, whole: '0, flag: 1'b1};
        errors = 0;
        hold_request = 1'b0;
        latitude_shadow = saa_pkg::LAT_RESET;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_hour_angle = '0;
        i_elevation = '0;
        i_day_of_year = 9'd1;
        i_cfg_valid = 1'b0;
        i_site_latitude = '0;

        // hour, elevation, day, typed-in flag, typed-in result
        directed_rows = '{
            '{16'sd0,      15'sd0,      9'd81,  1'b0, flagged},
            '{16'sd0,      15'sd4500,   9'd172, 1'b0, flagged},
            '{16'sd18000,  15'sd1000,   9'd1,   1'b0, flagged},
            '{-16'sd18000, 15'sd1000,   9'd366, 1'b0, flagged},
            '{16'sd9000,   -15'sd8999,  9'd81,  1'b0, flagged},
            '{-16'sd9000,  15'sd8999,   9'd264, 1'b0, flagged},
            '{16'sd32767,  15'sd2000,   9'd100, 1'b0, flagged},   // hour wraps
            '{-16'sd32768, 15'sd2000,   9'd100, 1'b0, flagged},
            '{16'sd4500,   15'sd3000,   9'd0,   1'b0, flagged},   // day out of range
            '{16'sd4500,   15'sd3000,   9'd511, 1'b0, flagged},
            '{16'sd0,      -15'sd3000,  9'd355, 1'b0, flagged},   // sun due north
            '{16'sd0,      15'sd100,    9'd172, 1'b0, flagged},
            '{16'sd1,      15'sd1,      9'd200, 1'b0, flagged},
            '{-16'sd1,     -15'sd1,     9'd45,  1'b0, flagged},
            // elevation at or past the zenith or nadir: azimuth undefined
            '{16'sd1234,   15'sd9000,   9'd10,  1'b1, flagged},
            '{-16'sd1234,  -15'sd9000,  9'd10,  1'b1, flagged},
            '{16'sd32767,  15'sd16383,  9'd511, 1'b1, flagged},
            '{-16'sd32768, -15'sd16384, 9'd0,   1'b1, flagged}
        };

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset latitude first, then the directed rows again at a southern extreme
        foreach (directed_rows[n])
            send_sample(directed_rows[n].ha, directed_rows[n].el, directed_rows[n].day,
                        directed_rows[n].fixed, directed_rows[n].result);
        random_burst_traffic(80);

        write_latitude(saa_pkg::LAT_MAX);
        random_burst_traffic(80);
        // long receiver hold while the sender keeps offering: the core must stall its input
        hold_request = 1'b1;
        random_burst_traffic(120);

        write_latitude(saa_pkg::LAT_MIN);
        foreach (directed_rows[n])
            send_sample(directed_rows[n].ha, directed_rows[n].el, directed_rows[n].day,
                        directed_rows[n].fixed, directed_rows[n].result);
        random_burst_traffic(60);

        // sender waits for the pipeline to drain, then resumes
        idle_cycles(1);
        wait (pending_azimuths.size() == 0);
        random_burst_traffic(20);

        write_latitude(15'sd0);
        random_burst_traffic(60);
        write_latitude(15'sd16383);          // saturates to the north limit
        random_burst_traffic(40);
        write_latitude(-15'sd16384);         // saturates to the south limit
        random_burst_traffic(40);
        write_latitude(15'($signed($urandom_range(0, 17998)) - 8999));
        random_burst_traffic(80);

        idle_cycles(1);
        wait (pending_azimuths.size() == 0);
        repeat (saa_pkg::LAT + 10) @(posedge i_clk);
        if (pending_azimuths.size() != 0) begin
            $error("%0d transactions never came out", pending_azimuths.size());
            errors++;
        end
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2000000;
        $display("simulation failed");
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/saa_pkg.sv
hdl/saa_sincos.sv
hdl/saa_vector.sv
hdl/solar_azimuth_angle_core.sv
dv/testbench.sv
